/* design/ptcr_pkg.sv */
// ----------------------------------------------------------------------------
// ptcr_pkg
// Shared types, codes and the fixed parameter table of the command responder.
// ----------------------------------------------------------------------------
`default_nettype none

package ptcr_pkg;

    localparam int TABLE_SIZE = 13;
    localparam int TIDX_W     = 4;

    // Request command codes.
    localparam logic [2:0] CMD_GET       = 3'd0;
    localparam logic [2:0] CMD_SET       = 3'd1;
    localparam logic [2:0] CMD_GET_ALL   = 3'd2;
    localparam logic [2:0] CMD_RESET_DEF = 3'd3;

    // Response status codes.
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_UNKNOWN = 2'd1;
    localparam logic [1:0] ST_BUSY    = 2'd2;
    localparam logic [1:0] ST_BADOP   = 2'd3;

    localparam logic [15:0] ENTRY_ID [TABLE_SIZE] = '{
        16'h0101, 16'h0102, 16'h0103, 16'h0104, 16'h0105,
        16'h0110, 16'h0111, 16'h0112, 16'h0113, 16'h0114,
        16'h0120, 16'h0121, 16'h0122
    };

    localparam logic [15:0] ENTRY_DEFAULT [TABLE_SIZE] = '{
        16'd1500, 16'd3071, 16'd4641, 16'd6212, 16'd300,
        16'd6242, 16'd400,  16'd250,  16'd6342, 16'd6442,
        16'd1100, 16'd1000, 16'd1000
    };

    localparam logic [1:0] ENTRY_PRIO [TABLE_SIZE] = '{
        2'd1, 2'd1, 2'd1, 2'd1, 2'd1,
        2'd2, 2'd2, 2'd2, 2'd2, 2'd2,
        2'd3, 2'd3, 2'd3
    };

    // Classified operation handed from the front end to the back end.
    typedef enum logic [2:0] {
        OP_GET,
        OP_SET,
        OP_LIST,
        OP_RESET,
        OP_BAD
    } t_op;

    typedef struct packed {
        t_op                op;
        logic [7:0]         seq;
        logic [15:0]        pid;
        logic [15:0]        nval;
        logic               wr;
        logic               hit;
        logic [TIDX_W-1:0]  idx;
    } t_cmd;

    typedef enum logic {
        BK_IDLE,
        BK_LIST
    } t_bk_state;

endpackage

`default_nettype wire

/* design/ptcr_front.sv */
// ----------------------------------------------------------------------------
// ptcr_front
// Classifies a request and looks its identifier up in the parameter table.
// ----------------------------------------------------------------------------
`default_nettype none

module ptcr_front
    import ptcr_pkg::*;
#(
    parameter int NUM_ENTRIES = 13
) (
    input  wire logic [2:0]  i_command,
    input  wire logic [7:0]  i_seq,
    input  wire logic [15:0] i_target_id,
    input  wire logic [15:0] i_new_value,
    input  wire logic        i_wr_permit,
    output t_cmd             o_cmd
);

    logic              hit;
    logic [TIDX_W-1:0] idx;

    // Scanning downward leaves the lowest matching entry selected.
    always_comb begin
        hit = 1'b0;
        idx = '0;
        for (int i = TABLE_SIZE - 1; i >= 0; i--) begin
            if (i < NUM_ENTRIES && ENTRY_ID[i] == i_target_id) begin
                hit = 1'b1;
                idx = TIDX_W'(i);
            end
        end
    end

    always_comb begin
        o_cmd.seq  = i_seq;
        o_cmd.pid  = i_target_id;
        o_cmd.nval = i_new_value;
        o_cmd.wr   = i_wr_permit;
        o_cmd.hit  = hit;
        o_cmd.idx  = idx;
        unique case (i_command)
            CMD_GET:       o_cmd.op = OP_GET;
            CMD_SET:       o_cmd.op = OP_SET;
            CMD_GET_ALL:   o_cmd.op = OP_LIST;
            CMD_RESET_DEF: o_cmd.op = OP_RESET;
            default:       o_cmd.op = OP_BAD;
        endcase
    end

endmodule

`default_nettype wire

/* design/ptcr_cmd_queue.sv */
// ----------------------------------------------------------------------------
// ptcr_cmd_queue
// Two-entry queue of classified commands between front and back end.
// ----------------------------------------------------------------------------
`default_nettype none

module ptcr_cmd_queue
    import ptcr_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_cmd,
    output logic      o_full,
    input  wire logic i_pop,
    output logic      o_empty,
    output t_cmd      o_cmd
);

    localparam int Q_DEPTH = 2;
    localparam int PTR_W   = $clog2(Q_DEPTH);
    localparam int CNT_W   = $clog2(Q_DEPTH + 1);

    t_cmd             r_mem [Q_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CNT_W'(Q_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

`default_nettype wire

/* design/ptcr_back.sv */
// ----------------------------------------------------------------------------
// ptcr_back
// Executes commands against the value store and drives the response register.
// ----------------------------------------------------------------------------
`default_nettype none

module ptcr_back
    import ptcr_pkg::*;
#(
    parameter int          NUM_ENTRIES = 13,
    parameter logic [15:0] LIST_END_ID = 16'hFFFF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_q_empty,
    input  wire t_cmd        i_cmd,
    output logic             o_q_pop,
    input  wire logic        i_pop,
    output logic             o_empty,
    output logic [7:0]       o_resp_seq,
    output logic [1:0]       o_status,
    output logic [15:0]      o_resp_id,
    output logic [15:0]      o_resp_value,
    output logic [1:0]       o_priority_res,
    output logic             o_last
);

    t_bk_state         r_state;
    t_bk_state         n_state;
    logic [15:0]       r_store [TABLE_SIZE];
    logic [TIDX_W-1:0] r_cnt;
    logic [7:0]        r_lseq;

    logic              r_ov;
    logic [7:0]        r_seq;
    logic [1:0]        r_status;
    logic [15:0]       r_id;
    logic [15:0]       r_value;
    logic [1:0]        r_prio;
    logic              r_last;

    logic              slot_free;
    logic              out_load;
    logic              at_end;
    logic [7:0]        n_seq;
    logic [1:0]        n_status;
    logic [15:0]       n_id;
    logic [15:0]       n_value;
    logic [1:0]        n_prio;
    logic              n_last;
    logic              st_write;
    logic              st_restore;
    logic [15:0]       cur_value;

    assign slot_free = !r_ov || i_pop;
    assign at_end    = (r_cnt == TIDX_W'(NUM_ENTRIES));
    assign cur_value = r_store[i_cmd.idx];

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_IDLE: begin
                if (!i_q_empty && slot_free && i_cmd.op == OP_LIST) begin
                    n_state = BK_LIST;
                end
            end
            BK_LIST: begin
                if (slot_free && at_end) begin
                    n_state = BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    always_comb begin
        o_q_pop    = 1'b0;
        out_load   = 1'b0;
        st_write   = 1'b0;
        st_restore = 1'b0;
        n_seq      = i_cmd.seq;
        n_status   = ST_OK;
        n_id       = i_cmd.pid;
        n_value    = '0;
        n_prio     = '0;
        n_last     = 1'b1;
        unique case (r_state)
            BK_IDLE: begin
                if (!i_q_empty && slot_free) begin
                    o_q_pop = 1'b1;
                    out_load = (i_cmd.op != OP_LIST);
                    case (i_cmd.op)
                        OP_GET: begin
                            if (i_cmd.hit) begin
                                n_value = cur_value;
                                n_prio  = ENTRY_PRIO[i_cmd.idx];
                            end else begin
                                n_status = ST_UNKNOWN;
                            end
                        end
                        OP_SET: begin
                            if (!i_cmd.wr) begin
                                n_status = ST_BUSY;
                                if (i_cmd.hit) begin
                                    n_value = cur_value;
                                    n_prio  = ENTRY_PRIO[i_cmd.idx];
                                end
                            end else if (!i_cmd.hit) begin
                                n_status = ST_UNKNOWN;
                            end else begin
                                st_write = 1'b1;
                                n_value  = i_cmd.nval;
                                n_prio   = ENTRY_PRIO[i_cmd.idx];
                            end
                        end
                        OP_RESET: begin
                            st_restore = i_cmd.wr;
                            n_status   = i_cmd.wr ? ST_OK : ST_BUSY;
                            n_id       = LIST_END_ID;
                            n_value    = 16'(NUM_ENTRIES);
                        end
                        OP_LIST: begin
                            n_last = 1'b0;
                        end
                        default: begin
                            n_status = ST_BADOP;
                        end
                    endcase
                end
            end
            BK_LIST: begin
                n_seq = r_lseq;
                if (slot_free) begin
                    out_load = 1'b1;
                    if (at_end) begin
                        n_id    = LIST_END_ID;
                        n_value = 16'(NUM_ENTRIES);
                    end else begin
                        n_id    = ENTRY_ID[r_cnt];
                        n_value = r_store[r_cnt];
                        n_prio  = ENTRY_PRIO[r_cnt];
                        n_last  = 1'b0;
                    end
                end
            end
            default: begin
                n_last = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
            r_cnt   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == BK_IDLE) begin
                r_cnt <= '0;
            end else if (out_load) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (out_load) begin
                r_ov <= 1'b1;
            end else if (i_pop) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || st_restore) begin
            r_store <= ENTRY_DEFAULT;
        end else if (st_write) begin
            r_store[i_cmd.idx] <= i_cmd.nval;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_lseq <= i_cmd.seq;
        end
        if (out_load) begin
            r_seq    <= n_seq;
            r_status <= n_status;
            r_id     <= n_id;
            r_value  <= n_value;
            r_prio   <= n_prio;
            r_last   <= n_last;
        end
    end

    assign o_empty        = !r_ov;
    assign o_resp_seq     = r_seq;
    assign o_status       = r_status;
    assign o_resp_id      = r_id;
    assign o_resp_value   = r_value;
    assign o_priority_res = r_prio;
    assign o_last         = r_last;

    a_pop_needs_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |-> !i_q_empty)
        else $error("command popped from an empty queue");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == BK_LIST |-> r_cnt <= TIDX_W'(NUM_ENTRIES))
        else $error("list counter ran past the end marker");

    a_non_last_in_list: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && !n_last) |-> r_state == BK_LIST)
        else $error("non-final response outside a list burst");

    a_list_ends_marked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BK_LIST && n_state == BK_IDLE) |-> (out_load && n_last))
        else $error("list burst left without its end marker");

endmodule

`default_nettype wire

/* design/parameter_table_command_responder_core.sv */
// ----------------------------------------------------------------------------
// parameter_table_command_responder_core
// Command responder for a table of thirteen 16-bit tuning parameters.
// ----------------------------------------------------------------------------
// Path: a request is held in the command queue, then in the response register.
// Throughput: one single-answer request per cycle while pop keeps up; a
//   get-all is first taken from the queue, then the back end steps through
//   the store, loading a response for each entry and then the end marker.
// Reset: synchronous, active low; the store returns to its default values
//   at once and the command queue and response register are emptied.
// ----------------------------------------------------------------------------
`default_nettype none

module parameter_table_command_responder_core
    import ptcr_pkg::*;
#(
    parameter int          NUM_ENTRIES = 13,
    parameter logic [15:0] LIST_END_ID = 16'hFFFF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Request side: a transaction completes when push is high and full low.
    input  wire logic        push,
    output logic             full,
    input  wire logic [2:0]  i_command,
    input  wire logic [7:0]  i_seq,
    input  wire logic [15:0] i_target_id,
    input  wire logic [15:0] i_new_value,
    input  wire logic        i_wr_permit,
    // Response side: a transaction completes when pop is high and empty low.
    output logic             empty,
    input  wire logic        pop,
    output logic [7:0]       o_resp_seq,
    output logic [1:0]       o_status,
    output logic [15:0]      o_resp_id,
    output logic [15:0]      o_resp_value,
    output logic [1:0]       o_priority_res,
    output logic             o_last
);

    // The front end classifies the request and resolves the identifier to a
    // table index in the same cycle, so the queue stores ready-to-run work.
    t_cmd front_cmd;
    t_cmd queue_cmd;
    logic queue_empty;
    logic queue_pop;

    ptcr_front #(
        .NUM_ENTRIES (NUM_ENTRIES)
    ) u_front (
        .i_command   (i_command),
        .i_seq       (i_seq),
        .i_target_id (i_target_id),
        .i_new_value (i_new_value),
        .i_wr_permit (i_wr_permit),
        .o_cmd       (front_cmd)
    );

    // The queue lets new requests land while the back end is busy with a
    // get-all burst or is held off by a full response register.
    ptcr_cmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .o_full  (full),
        .i_pop   (queue_pop),
        .o_empty (queue_empty),
        .o_cmd   (queue_cmd)
    );

    // The back end owns the value store and executes commands in order, so
    // a get always observes every earlier set.
    ptcr_back #(
        .NUM_ENTRIES (NUM_ENTRIES),
        .LIST_END_ID (LIST_END_ID)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_empty      (queue_empty),
        .i_cmd          (queue_cmd),
        .o_q_pop        (queue_pop),
        .i_pop          (pop),
        .o_empty        (empty),
        .o_resp_seq     (o_resp_seq),
        .o_status       (o_status),
        .o_resp_id      (o_resp_id),
        .o_resp_value   (o_resp_value),
        .o_priority_res (o_priority_res),
        .o_last         (o_last)
    );

endmodule

`default_nettype wire

/* tb/sv/parameter_table_command_responder_core_tb.sv */
// ----------------------------------------------------------------------------
// parameter_table_command_responder_core_tb
// Self-checking bench for the parameter table command responder. Requests go
// in through the push/full queue port and responses come out through the
// empty/pop port. Each request is answered by a predictor that keeps its own
// copy of the tuning table, and every response transaction is compared
// field by field with the oldest prediction. A directed burst comes first,
// then random traffic under several sender and receiver idling patterns.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module parameter_table_command_responder_core_tb;
    import ptcr_pkg::*;

    localparam int          TUNING_ENTRIES = 13;
    localparam logic [15:0] LIST_END_MARK  = 16'hFFFF;

    // Command codes 4 through 7 carry no operation and must answer bad-op.
    localparam logic [2:0] CMD_FIRST_BAD  = 3'd4;
    localparam logic [2:0] CMD_SECOND_BAD = 3'd5;
    localparam logic [2:0] CMD_THIRD_BAD  = 3'd6;
    localparam logic [2:0] CMD_LAST_BAD   = 3'd7;

    // Independent copy of the fixed table, so that a wrong table in the
    // design package shows up as a mismatch rather than being mirrored.
    localparam logic [15:0] TUNING_ID [TUNING_ENTRIES] = '{
        16'h0101, 16'h0102, 16'h0103, 16'h0104, 16'h0105,
        16'h0110, 16'h0111, 16'h0112, 16'h0113, 16'h0114,
        16'h0120, 16'h0121, 16'h0122
    };
    localparam logic [15:0] TUNING_DEFAULT [TUNING_ENTRIES] = '{
        16'd1500, 16'd3071, 16'd4641, 16'd6212, 16'd300,
        16'd6242, 16'd400,  16'd250,  16'd6342, 16'd6442,
        16'd1100, 16'd1000, 16'd1000
    };
    localparam logic [1:0] TUNING_PRIO [TUNING_ENTRIES] = '{
        2'd1, 2'd1, 2'd1, 2'd1, 2'd1,
        2'd2, 2'd2, 2'd2, 2'd2, 2'd2,
        2'd3, 2'd3, 2'd3
    };

    typedef struct {
        logic [2:0]  command;
        logic [7:0]  seq;
        logic [15:0] target_id;
        logic [15:0] new_value;
        logic        wr_permit;
    } t_request;

    typedef struct {
        logic [7:0]  seq;
        logic [1:0]  status;
        logic [15:0] id;
        logic [15:0] value;
        logic [1:0]  prio;
        logic        last;
    } t_response;

    logic        i_clk;
    logic        i_rst_n;
    logic        push;
    logic        full;
    logic [2:0]  i_command;
    logic [7:0]  i_seq;
    logic [15:0] i_target_id;
    logic [15:0] i_new_value;
    logic        i_wr_permit;
    logic        empty;
    logic        pop;
    logic [7:0]  o_resp_seq;
    logic [1:0]  o_status;
    logic [15:0] o_resp_id;
    logic [15:0] o_resp_value;
    logic [1:0]  o_priority_res;
    logic        o_last;

    t_request    pending_requests[$];
    t_response   responses_owed[$];
    logic [15:0] tuning_store [TUNING_ENTRIES];

    // The request currently offered on the input port, and whether it is
    // still waiting for its transaction.
    t_request    offered;
    logic        offer_open;

    // Idling percentages of the current traffic phase.
    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    int unsigned error_count;

    parameter_table_command_responder_core u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_command      (i_command),
        .i_seq          (i_seq),
        .i_target_id    (i_target_id),
        .i_new_value    (i_new_value),
        .i_wr_permit    (i_wr_permit),
        .empty          (empty),
        .pop            (pop),
        .o_resp_seq     (o_resp_seq),
        .o_status       (o_status),
        .o_resp_id      (o_resp_id),
        .o_resp_value   (o_resp_value),
        .o_priority_res (o_priority_res),
        .o_last         (o_last)
    );

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    function automatic t_response make_response(logic [7:0] seq, logic [1:0] status,
                                                logic [15:0] id, logic [15:0] value,
                                                logic [1:0] prio, logic last);
        t_response r;
        r.seq    = seq;
        r.status = status;
        r.id     = id;
        r.value  = value;
        r.prio   = prio;
        r.last   = last;
        return r;
    endfunction

    // Works out the responses that one accepted request must produce and
    // applies its effect on the table copy.
    function void answer_command(t_request rq);
        int hit_idx;
        hit_idx = -1;
        // The first matching entry wins, should the table ever hold duplicates.
        for (int i = TUNING_ENTRIES - 1; i >= 0; i--) begin
            if (TUNING_ID[i] == rq.target_id) begin
                hit_idx = i;
            end
        end
        case (rq.command)
            CMD_GET: begin
                if (hit_idx < 0) begin
                    responses_owed.push_back(make_response(rq.seq, ST_UNKNOWN,
                        rq.target_id, 16'd0, 2'd0, 1'b1));
                end else begin
                    responses_owed.push_back(make_response(rq.seq, ST_OK,
                        TUNING_ID[hit_idx], tuning_store[hit_idx],
                        TUNING_PRIO[hit_idx], 1'b1));
                end
            end
            CMD_SET: begin
                // Busy is checked before the lookup, so a refused write to a
                // known entry still reports its current value and priority.
                if (!rq.wr_permit) begin
                    if (hit_idx < 0) begin
                        responses_owed.push_back(make_response(rq.seq, ST_BUSY,
                            rq.target_id, 16'd0, 2'd0, 1'b1));
                    end else begin
                        responses_owed.push_back(make_response(rq.seq, ST_BUSY,
                            rq.target_id, tuning_store[hit_idx],
                            TUNING_PRIO[hit_idx], 1'b1));
                    end
                end else if (hit_idx < 0) begin
                    responses_owed.push_back(make_response(rq.seq, ST_UNKNOWN,
                        rq.target_id, 16'd0, 2'd0, 1'b1));
                end else begin
                    tuning_store[hit_idx] = rq.new_value;
                    responses_owed.push_back(make_response(rq.seq, ST_OK,
                        TUNING_ID[hit_idx], rq.new_value, TUNING_PRIO[hit_idx], 1'b1));
                end
            end
            CMD_GET_ALL: begin
                for (int i = 0; i < TUNING_ENTRIES; i++) begin
                    responses_owed.push_back(make_response(rq.seq, ST_OK,
                        TUNING_ID[i], tuning_store[i], TUNING_PRIO[i], 1'b0));
                end
                responses_owed.push_back(make_response(rq.seq, ST_OK,
                    LIST_END_MARK, 16'(TUNING_ENTRIES), 2'd0, 1'b1));
            end
            CMD_RESET_DEF: begin
                if (rq.wr_permit) begin
                    for (int i = 0; i < TUNING_ENTRIES; i++) begin
                        tuning_store[i] = TUNING_DEFAULT[i];
                    end
                end
                responses_owed.push_back(make_response(rq.seq,
                    rq.wr_permit ? ST_OK : ST_BUSY,
                    LIST_END_MARK, 16'(TUNING_ENTRIES), 2'd0, 1'b1));
            end
            default: begin
                responses_owed.push_back(make_response(rq.seq, ST_BADOP,
                    rq.target_id, 16'd0, 2'd0, 1'b1));
            end
        endcase
    endfunction

    function void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            error_count++;
        end
    endfunction

    task automatic queue_request(logic [2:0] command, logic [7:0] seq,
                                 logic [15:0] target_id, logic [15:0] new_value,
                                 logic wr_permit);
        t_request rq;
        rq.command   = command;
        rq.seq       = seq;
        rq.target_id = target_id;
        rq.new_value = new_value;
        rq.wr_permit = wr_permit;
        pending_requests.push_back(rq);
    endtask

    // Random traffic: mostly well-formed commands on known entries, with a
    // share of near-miss identifiers, bad operations and raw noise.
    task automatic queue_random_request();
        int unsigned pick;
        logic [2:0]  command;
        logic [15:0] target_id;
        logic        wr_permit;
        pick      = $urandom_range(99);
        target_id = 16'($urandom);
        wr_permit = 1'($urandom);
        command   = 3'($urandom);
        if (pick < 30) begin
            command   = CMD_GET;
            target_id = TUNING_ID[$urandom_range(TUNING_ENTRIES - 1)];
        end else if (pick < 55) begin
            command   = CMD_SET;
            target_id = TUNING_ID[$urandom_range(TUNING_ENTRIES - 1)];
            wr_permit = ($urandom_range(99) < 80);
        end else if (pick < 65) begin
            // One flipped bit away from a real identifier, or fully random.
            command = $urandom_range(1) ? CMD_GET : CMD_SET;
            if ($urandom_range(1)) begin
                target_id = TUNING_ID[$urandom_range(TUNING_ENTRIES - 1)]
                            ^ (16'd1 << $urandom_range(15));
            end
        end else if (pick < 73) begin
            command = CMD_GET_ALL;
        end else if (pick < 80) begin
            command = CMD_RESET_DEF;
        end else if (pick < 88) begin
            command  = 3'($urandom_range(CMD_LAST_BAD, CMD_FIRST_BAD));
        end
        queue_request(command, 8'($urandom), target_id, 16'($urandom), wr_permit);
    endtask

    // Request side. Acceptance is taken at the rising edge, where the offered
    // transaction is also handed to the predictor.
    always @(posedge i_clk) begin
        if (i_rst_n && push && !full) begin
            answer_command(offered);
            offer_open <= 1'b0;
        end
    end

    // A new request is offered at the falling edge once the previous one has
    // gone through, unless the sender decides to stay idle this cycle.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else if (!offer_open) begin
            if (pending_requests.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                offered     = pending_requests.pop_front();
                offer_open  <= 1'b1;
                push        <= 1'b1;
                i_command   <= offered.command;
                i_seq       <= offered.seq;
                i_target_id <= offered.target_id;
                i_new_value <= offered.new_value;
                i_wr_permit <= offered.wr_permit;
            end else begin
                push <= 1'b0;
            end
        end
    end

    // Response side: compare every completed pop transaction with the oldest
    // owed response.
    always @(posedge i_clk) begin : response_check
        t_response want;
        if (i_rst_n && pop && !empty) begin
            if (responses_owed.size() == 0) begin
                $error("response with none owed: seq 0x%0h id 0x%0h",
                       o_resp_seq, o_resp_id);
                error_count++;
            end else begin
                want = responses_owed.pop_front();
                check_field("resp_seq", want.seq, o_resp_seq);
                check_field("status", want.status, o_status);
                check_field("resp_id", want.id, o_resp_id);
                check_field("resp_value", want.value, o_resp_value);
                check_field("priority_res", want.prio, o_priority_res);
                check_field("last", want.last, o_last);
            end
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            pop <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Generous bound on the whole run; a correct run finishes far earlier.
    initial begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

    initial begin
        push           = 1'b0;
        pop            = 1'b0;
        i_command      = CMD_GET;
        i_seq          = 8'd0;
        i_target_id    = 16'd0;
        i_new_value    = 16'd0;
        i_wr_permit    = 1'b0;
        offer_open     = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        error_count    = 0;
        for (int i = 0; i < TUNING_ENTRIES; i++) begin
            tuning_store[i] = TUNING_DEFAULT[i];
        end

        i_rst_n = 1'b0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part: table edges, unknown identifiers, refused writes,
        // listing after changes and after a restore, both outcomes of reset-defaults,
        // and every bad operation code.
        queue_request(CMD_GET, 8'h00, TUNING_ID[0], 16'h0000, 1'b0);
        queue_request(CMD_GET, 8'hFF, TUNING_ID[TUNING_ENTRIES - 1], 16'hFFFF, 1'b1);
        queue_request(CMD_GET, 8'h01, 16'h0000, 16'h1234, 1'b1);
        queue_request(CMD_GET, 8'h02, 16'hFFFF, 16'h0000, 1'b0);
        queue_request(CMD_SET, 8'h03, TUNING_ID[4], 16'hFFFF, 1'b1);
        queue_request(CMD_SET, 8'h04, TUNING_ID[10], 16'h0000, 1'b1);
        queue_request(CMD_SET, 8'h05, TUNING_ID[4], 16'h5A5A, 1'b0);
        queue_request(CMD_SET, 8'h06, 16'h0106, 16'hA5A5, 1'b0);
        queue_request(CMD_SET, 8'h07, 16'h0123, 16'h7777, 1'b1);
        queue_request(CMD_GET, 8'h08, TUNING_ID[4], 16'h0000, 1'b1);
        queue_request(CMD_GET_ALL, 8'h09, 16'hFFFF, 16'hFFFF, 1'b1);
        queue_request(CMD_RESET_DEF, 8'h0A, TUNING_ID[4], 16'h0000, 1'b0);
        queue_request(CMD_GET, 8'h0B, TUNING_ID[10], 16'h0000, 1'b0);
        queue_request(CMD_RESET_DEF, 8'h0C, 16'h0000, 16'hFFFF, 1'b1);
        queue_request(CMD_GET_ALL, 8'h0D, 16'h0000, 16'h0000, 1'b0);
        queue_request(CMD_FIRST_BAD, 8'h0E, TUNING_ID[0], 16'hFFFF, 1'b1);
        queue_request(CMD_SECOND_BAD, 8'h0F, 16'hFFFF, 16'h0000, 1'b0);
        queue_request(CMD_THIRD_BAD, 8'h10, 16'h8000, 16'h8000, 1'b1);
        queue_request(CMD_LAST_BAD, 8'hAA, 16'h5555, 16'hAAAA, 1'b0);

        // Four random phases, each with its own idling pattern. A phase
        // starts only once the previous phase's requests have all gone in.
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 69; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 69; end
                default: begin send_idle_pct = 20; recv_stall_pct = 20; end
            endcase
            repeat (35) queue_random_request();
            while (pending_requests.size() > 0 || offer_open) @(posedge i_clk);
        end

        // Drain every owed response, then keep the clock running so that anything
        // stray can surface.
        while (responses_owed.size() > 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        if (error_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

`default_nettype wire

/* parameter_table_command_responder_core.f */
design/ptcr_pkg.sv
design/ptcr_front.sv
design/ptcr_cmd_queue.sv
design/ptcr_back.sv
design/parameter_table_command_responder_core.sv
tb/sv/parameter_table_command_responder_core_tb.sv
